[design/prm_pkg.sv]
// Shared constants, codes and record types of the peer rendezvous matcher.
// Used by the top level; the generic RAM stands alone.
`timescale 1ns / 1ps

package prm_pkg;

   // Table geometry.
   localparam int PEERS   = 64;
   localparam int IDX_W   = $clog2(PEERS);
   localparam int CNT_W   = $clog2(PEERS + 1);
   localparam int LINK_AW = 2 * IDX_W;
   localparam int LIM_W   = (CNT_W > 7) ? CNT_W : 7;

   // Datagram and register fields.
   localparam logic [16:0] MSG_LEN          = 17'd8;
   localparam logic [6:0]  MAX_USERS_RESET  = 7'd64;
   localparam logic [7:0]  TIMEOUT_RESET    = 8'd3;

   // Register indexes.
   localparam logic CSR_MAX_USERS    = 1'b0;
   localparam logic CSR_IDLE_TIMEOUT = 1'b1;

   // Reply kinds.
   localparam logic [1:0] KIND_WAIT        = 2'd0;
   localparam logic [1:0] KIND_PEER_INFO   = 2'd1;
   localparam logic [1:0] KIND_SENDER_INFO = 2'd2;

   // One peer record as stored in the record RAM.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [63:0]      session;
      logic [31:0]      seen;
      logic [15:0]      port;
      logic [31:0]      addr;
   } rec_type;

   // One reply as held in the output queue.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [31:0] info_addr;
      logic [15:0] info_port;
      logic        last;
   } rsp_type;

endpackage

[design/prm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module prm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[design/peer_rendezvous_matcher_unit.sv]
// Peer rendezvous matcher: pairs senders that present the same session id.
// Depends on prm_pkg and prm_ram.
//
// Usage:
//   req_*  : one received datagram per transfer (address, port, session id,
//            time in seconds, payload length). Only length 8 is processed.
//   rsp_*  : zero, one (wait reply) or two (peer info pair) replies per
//            datagram; tlast marks the final reply of a datagram and tuser
//            carries the reply kind.
//   csr_*  : register writes (max_users, idle_timeout_s), always ready.
// Processing: one datagram at a time. A datagram runs the idle check of every
//   record in use, then per evicted peer a link scrub of every record and the
//   move of the last record and its link list, then the lookup of the sender
//   and the match, which reads each candidate's link list. Every step is one
//   read of the record RAM or link RAM followed by its evaluation in the next
//   cycle.
// Reset: the table is empty, max_users = 64, idle_timeout_s = 3. No clearing
//   pass is needed, only records below the record count are read.
// Stall: replies wait in a two-entry output queue; the next datagram is
//   accepted and processed meanwhile, and waits only when it has replies to
//   deliver before the queue has drained.
`timescale 1ns / 1ps

module peer_rendezvous_matcher_unit (
   input  logic          clock,
   input  logic          reset,
   // tdata: src_addr[31:0], src_port[47:32], session_id[111:48],
   //        now_s[143:112], payload_len[160:144], zero fill [167:161]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [167:0]  req_tdata,
   // tdata: dest_addr[31:0], dest_port[47:32], info_addr[79:48],
   //        info_port[95:80]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,
   // tuser: reply_kind[1:0]
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   import prm_pkg::*;

   typedef enum logic [21:0] {
      ST_IDLE        = 22'd1 << 0,
      ST_EV_RD       = 22'd1 << 1,
      ST_EV_CHK      = 22'd1 << 2,
      ST_DR_RD       = 22'd1 << 3,
      ST_DR_CNT      = 22'd1 << 4,
      ST_DR_SCAN_RD  = 22'd1 << 5,
      ST_DR_SCAN_CHK = 22'd1 << 6,
      ST_DR_FIX      = 22'd1 << 7,
      ST_EV_MOVE     = 22'd1 << 8,
      ST_MV_REC      = 22'd1 << 9,
      ST_MV_RD       = 22'd1 << 10,
      ST_MV_WR       = 22'd1 << 11,
      ST_LK_RD       = 22'd1 << 12,
      ST_LK_CHK      = 22'd1 << 13,
      ST_MT_START    = 22'd1 << 14,
      ST_MT_RD       = 22'd1 << 15,
      ST_MT_CHK      = 22'd1 << 16,
      ST_HL_RD       = 22'd1 << 17,
      ST_HL_CHK      = 22'd1 << 18,
      ST_LINK_S      = 22'd1 << 19,
      ST_LINK_O      = 22'd1 << 20,
      ST_PUSH        = 22'd1 << 21
   } state_type;

   // Control state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [6:0]       max_users_ff;
   logic [7:0]       timeout_ff;
   logic [1:0]       q_cnt_ff, q_cnt_in;

   // Work registers.
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] s_ff, s_in;
   logic [31:0]      gone_ff, gone_in;
   logic             pair_ff, pair_in;
   rec_type          s_rec_ff, s_rec_in;
   rec_type          o_rec_ff, o_rec_in;

   // Latched datagram.
   logic [31:0]      addr_ff, addr_in;
   logic [15:0]      port_ff, port_in;
   logic [63:0]      sid_ff, sid_in;
   logic [31:0]      now_ff, now_in;

   // Output queue.
   rsp_type          q0_ff, q0_in;
   rsp_type          q1_ff, q1_in;

   // RAM ports.
   logic               rec_we;
   logic [IDX_W-1:0]   rec_waddr, rec_raddr;
   rec_type            rec_wdata, rec_rdata;
   logic               link_we;
   logic [LINK_AW-1:0] link_waddr, link_raddr;
   logic [31:0]        link_wdata, link_rdata;

   logic               req_fire, rsp_fire, full;
   logic [CNT_W-1:0]   last_rec;

   // Index of the last link entry of a list of length n (n is nonzero).
   function automatic logic [IDX_W-1:0] last_k(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] m;
      m = n - CNT_W'(1);
      return m[IDX_W-1:0];
   endfunction

   // Peer records and link lists.
   prm_ram #(.WIDTH($bits(rec_type)), .DEPTH(PEERS)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .raddr (rec_raddr),
      .rdata (rec_rdata)
   );

   prm_ram #(.WIDTH(32), .DEPTH(1 << LINK_AW)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {q0_ff.info_port, q0_ff.info_addr, q0_ff.dest_port, q0_ff.dest_addr};
   assign rsp_tuser  = q0_ff.kind;
   assign rsp_tlast  = q0_ff.last;
   assign csr_ready  = 1'b1;

   assign last_rec = total_ff - CNT_W'(1);
   assign full     = (LIM_W'(total_ff) >= LIM_W'(max_users_ff)) ||
                     (total_ff >= CNT_W'(PEERS));

   // Sequencer: every step reads one RAM entry and evaluates it in the next cycle.
   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      s_in       = s_ff;
      gone_in    = gone_ff;
      pair_in    = pair_ff;
      s_rec_in   = s_rec_ff;
      o_rec_in   = o_rec_ff;
      addr_in    = addr_ff;
      port_in    = port_ff;
      sid_in     = sid_ff;
      now_in     = now_ff;
      rec_we     = 1'b0;
      rec_waddr  = i_ff[IDX_W-1:0];
      rec_wdata  = o_rec_ff;
      rec_raddr  = j_ff[IDX_W-1:0];
      link_we    = 1'b0;
      link_waddr = {i_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};
      link_wdata = link_rdata;
      link_raddr = {j_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in = req_tdata[31:0];
               port_in = req_tdata[47:32];
               sid_in  = req_tdata[111:48];
               now_in  = req_tdata[143:112];
               i_in    = '0;
               if (req_tdata[160:144] == MSG_LEN) begin
                  state_in = ST_EV_RD;
               end
            end
         end
         // Idle check of record i.
         ST_EV_RD: begin
            rec_raddr = i_ff[IDX_W-1:0];
            if (i_ff >= total_ff) begin
               j_in     = '0;
               state_in = ST_LK_RD;
            end else begin
               state_in = ST_EV_CHK;
            end
         end
         ST_EV_CHK: begin
            if ({1'b0, now_ff} > ({1'b0, rec_rdata.seen} + 33'(timeout_ff))) begin
               gone_in  = rec_rdata.addr;
               j_in     = '0;
               state_in = ST_DR_RD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_EV_RD;
            end
         end
         // Remove the evicted address from the link list of record j.
         ST_DR_RD: begin
            if (j_ff >= total_ff) begin
               state_in = ST_EV_MOVE;
            end else begin
               state_in = ST_DR_CNT;
            end
         end
         ST_DR_CNT: begin
            o_rec_in = rec_rdata;
            n_in     = rec_rdata.count;
            k_in     = '0;
            state_in = ST_DR_SCAN_RD;
         end
         ST_DR_SCAN_RD: begin
            if (k_ff >= n_ff) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_DR_RD;
            end else begin
               state_in = ST_DR_SCAN_CHK;
            end
         end
         ST_DR_SCAN_CHK: begin
            if (link_rdata == gone_ff) begin
               link_raddr = {j_ff[IDX_W-1:0], last_k(n_ff)};
               state_in   = ST_DR_FIX;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_DR_SCAN_RD;
            end
         end
         ST_DR_FIX: begin
            link_we         = 1'b1;
            link_waddr      = {j_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};
            rec_we          = 1'b1;
            rec_waddr       = j_ff[IDX_W-1:0];
            rec_wdata       = o_rec_ff;
            rec_wdata.count = n_ff - CNT_W'(1);
            j_in            = j_ff + CNT_W'(1);
            state_in        = ST_DR_RD;
         end
         // Drop record i; the last record moves into its slot.
         ST_EV_MOVE: begin
            total_in  = last_rec;
            rec_raddr = last_rec[IDX_W-1:0];
            if (last_rec != i_ff) begin
               state_in = ST_MV_REC;
            end else begin
               state_in = ST_EV_RD;
            end
         end
         ST_MV_REC: begin
            rec_we    = 1'b1;
            rec_waddr = i_ff[IDX_W-1:0];
            rec_wdata = rec_rdata;
            n_in      = rec_rdata.count;
            k_in      = '0;
            state_in  = ST_MV_RD;
         end
         ST_MV_RD: begin
            link_raddr = {total_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};
            if (k_ff >= n_ff) begin
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_MV_WR;
            end
         end
         ST_MV_WR: begin
            link_we  = 1'b1;
            k_in     = k_ff + CNT_W'(1);
            state_in = ST_MV_RD;
         end
         // Look up the sender, or insert it if the table is not full.
         ST_LK_RD: begin
            if (j_ff >= total_ff) begin
               if (full) begin
                  state_in = ST_IDLE;
               end else begin
                  s_in      = total_ff;
                  s_rec_in  = '{count: '0, session: sid_ff, seen: now_ff,
                                port: port_ff, addr: addr_ff};
                  rec_we    = 1'b1;
                  rec_waddr = total_ff[IDX_W-1:0];
                  rec_wdata = s_rec_in;
                  total_in  = total_ff + CNT_W'(1);
                  state_in  = ST_MT_START;
               end
            end else begin
               state_in = ST_LK_CHK;
            end
         end
         ST_LK_CHK: begin
            if (rec_rdata.addr == addr_ff) begin
               s_in      = j_ff;
               s_rec_in  = rec_rdata;
               s_rec_in.port = port_ff;
               s_rec_in.seen = now_ff;
               rec_we    = 1'b1;
               rec_waddr = j_ff[IDX_W-1:0];
               rec_wdata = s_rec_in;
               state_in  = ST_MT_START;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_LK_RD;
            end
         end
         // Search for the first ready peer with the same id not yet linked to the sender.
         ST_MT_START: begin
            j_in = '0;
            if (s_rec_ff.port == 16'd0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MT_RD;
            end
         end
         ST_MT_RD: begin
            if (j_ff >= total_ff) begin
               pair_in  = 1'b0;
               state_in = ST_PUSH;
            end else if (j_ff == s_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               state_in = ST_MT_CHK;
            end
         end
         ST_MT_CHK: begin
            if (rec_rdata.port != 16'd0 && rec_rdata.session == s_rec_ff.session) begin
               o_rec_in = rec_rdata;
               k_in     = '0;
               state_in = ST_HL_RD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_MT_RD;
            end
         end
         // Is the candidate already linked to the sender?
         ST_HL_RD: begin
            if (k_ff >= o_rec_ff.count) begin
               state_in = ST_LINK_S;
            end else begin
               state_in = ST_HL_CHK;
            end
         end
         ST_HL_CHK: begin
            if (link_rdata == s_rec_ff.addr) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_MT_RD;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_HL_RD;
            end
         end
         // Link both sides and clear both ports.
         ST_LINK_S: begin
            rec_we         = 1'b1;
            rec_waddr      = s_ff[IDX_W-1:0];
            rec_wdata      = s_rec_ff;
            rec_wdata.port = 16'd0;
            link_waddr     = {s_ff[IDX_W-1:0], s_rec_ff.count[IDX_W-1:0]};
            link_wdata     = o_rec_ff.addr;
            if (s_rec_ff.count < CNT_W'(PEERS)) begin
               link_we         = 1'b1;
               rec_wdata.count = s_rec_ff.count + CNT_W'(1);
            end
            state_in = ST_LINK_O;
         end
         ST_LINK_O: begin
            rec_we         = 1'b1;
            rec_waddr      = j_ff[IDX_W-1:0];
            rec_wdata      = o_rec_ff;
            rec_wdata.port = 16'd0;
            link_waddr     = {j_ff[IDX_W-1:0], o_rec_ff.count[IDX_W-1:0]};
            link_wdata     = s_rec_ff.addr;
            if (o_rec_ff.count < CNT_W'(PEERS)) begin
               link_we         = 1'b1;
               rec_wdata.count = o_rec_ff.count + CNT_W'(1);
            end
            pair_in  = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (q_cnt_ff == 2'd0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output queue: loaded only when empty, drained from the head.
   always_comb begin
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      q_cnt_in = q_cnt_ff;
      if (rsp_fire) begin
         q0_in    = q1_ff;
         q_cnt_in = q_cnt_ff - 2'd1;
      end
      if (state_ff == ST_PUSH && q_cnt_ff == 2'd0) begin
         if (pair_ff) begin
            q0_in    = '{kind: KIND_PEER_INFO, dest_addr: s_rec_ff.addr,
                         dest_port: s_rec_ff.port, info_addr: o_rec_ff.addr,
                         info_port: o_rec_ff.port, last: 1'b0};
            q1_in    = '{kind: KIND_SENDER_INFO, dest_addr: o_rec_ff.addr,
                         dest_port: o_rec_ff.port, info_addr: s_rec_ff.addr,
                         info_port: s_rec_ff.port, last: 1'b1};
            q_cnt_in = 2'd2;
         end else begin
            q0_in    = '{kind: KIND_WAIT, dest_addr: s_rec_ff.addr,
                         dest_port: s_rec_ff.port, info_addr: 32'd0,
                         info_port: 16'd0, last: 1'b1};
            q_cnt_in = 2'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         q_cnt_ff     <= 2'd0;
         max_users_ff <= MAX_USERS_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         q_cnt_ff <= q_cnt_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAX_USERS:    max_users_ff <= csr_wdata[6:0];
               CSR_IDLE_TIMEOUT: timeout_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Work and payload registers.
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      s_ff     <= s_in;
      gone_ff  <= gone_in;
      pair_ff  <= pair_in;
      s_rec_ff <= s_rec_in;
      o_rec_ff <= o_rec_in;
      addr_ff  <= addr_in;
      port_ff  <= port_in;
      sid_ff   <= sid_in;
      now_ff   <= now_in;
      q0_ff    <= q0_in;
      q1_ff    <= q1_in;
   end

   // The output queue never holds more than one datagram's replies.
   assert property (@(posedge clock) disable iff (reset) q_cnt_ff <= 2'd2)
      else $error("output queue overflow");

   // The record count stays within the table.
   assert property (@(posedge clock) disable iff (reset) total_ff <= CNT_W'(PEERS))
      else $error("record count beyond table size");

   // Replies are loaded once the queue is empty and leave it non-empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && q_cnt_ff == 2'd0) |=> (q_cnt_ff != 2'd0))
      else $error("replies not loaded");

   // Peer info to the sender is never the final reply of a datagram.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PEER_INFO) |-> !rsp_tlast)
      else $error("peer info reply marked last");

   // The sequencer leaves idle only on a transfer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_fire) |=> (state_ff == ST_IDLE))
      else $error("sequencer started without a datagram");

endmodule
